// File: rtl/core/haraka256_fold32_hash_core_defines.svh
// ---------------------------------------------------------------------------
// haraka256_fold32_hash_core_defines
// Assertion macros shared by the hash core modules.
// ---------------------------------------------------------------------------
`ifndef HARAKA256_FOLD32_HASH_CORE_DEFINES_SVH
`define HARAKA256_FOLD32_HASH_CORE_DEFINES_SVH
// assert that a implies b on the next clock edge, outside reset
`define HK_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
// assert that a implies b on the same clock edge, outside reset
`define HK_ASSERT_NOW(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`endif

// File: rtl/core/hk_pkg.sv
// ---------------------------------------------------------------------------
// hk_pkg
// Shared constants, S-box and AES round functions for the hash core.
// ---------------------------------------------------------------------------
package hk_pkg;

   localparam int unsigned AesRounds = 10;
   localparam int unsigned MsgWidth  = 256;
   localparam int unsigned DigWidth  = 32;
   localparam logic [15:0] LowFoldMask = 16'hffff;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // round keys, lane 0 in bits 31:0
   localparam logic [127:0] RKEY [20] = '{
      {32'h0684704c,32'he620c00a,32'hb2c5fef0,32'h75817b9d},
      {32'h8b66b4e1,32'h88f3a06b,32'h640f6ba4,32'h2f08f717},
      {32'h3402de2d,32'h53f28498,32'hcf029d60,32'h9f029114},
      {32'h0ed6eae6,32'h2e7b4f08,32'hbbf3bcaf,32'hfd5b4f79},
      {32'hcbcfb0cb,32'h4872448b,32'h79eecd1c,32'hbe397044},
      {32'h7eeacdee,32'h6e9032b7,32'h8d5335ed,32'h2b8a057b},
      {32'h67c28f43,32'h5e2e7cd0,32'he2412761,32'hda4fef1b},
      {32'h2924d9b0,32'hafcacc07,32'h675ffde2,32'h1fc70b3b},
      {32'hab4d63f1,32'he6867fe9,32'hecdb8fca,32'hb9d465ee},
      {32'h1c30bf84,32'hd4b7cd64,32'h5b2a404f,32'had037e33},
      {32'hb2cc0bb9,32'h941723bf,32'h69028b2e,32'h8df69800},
      {32'hfa0478a6,32'hde6f5572,32'h4aaa9ec8,32'h5c9d2d8a},
      {32'hdfb49f2b,32'h6b772a12,32'h0efa4f2e,32'h29129fd4},
      {32'h1ea10344,32'hf449a236,32'h32d611ae,32'hbb6a12ee},
      {32'haf044988,32'h4b050084,32'h5f9600c9,32'h9ca8eca6},
      {32'h21025ed8,32'h9d199c4f,32'h78a2c7e3,32'h27e593ec},
      {32'hbf3aaaf8,32'ha759c9b7,32'hb9282ecd,32'h82d40173},
      {32'h6260700d,32'h6186b017,32'h37f2efd9,32'h10307d6b},
      {32'h5aca45c2,32'h21300443,32'h81c29153,32'hf6fc9ac6},
      {32'h9223973c,32'h226b68bb,32'h2caf92e8,32'h36d1943a}
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one AES encryption round, byte 4*c+r at bits 32*c+8*r
   function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] key);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = SBOX[st[32*((c+r)%4)+8*r +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         o[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         o[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         o[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         o[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return o ^ key;
   endfunction

endpackage

// File: rtl/core/hk_stage.sv
// ---------------------------------------------------------------------------
// hk_stage
// One pipeline stage: an AES round on each half, optional unpack mix.
// Stalls when it holds a transaction and the next stage is full and not draining.
// ---------------------------------------------------------------------------
module hk_stage #(
   parameter int unsigned Step = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  logic [255:0] up_state,
   input  logic [255:0] up_orig,
   output logic         dn_valid,
   input  logic         dn_ready,
   output logic [255:0] dn_state,
   output logic [255:0] dn_orig
);
   logic         valid_ff;
   logic [255:0] state_ff, orig_ff, state_in;
   logic [127:0] lo, hi;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      lo = hk_pkg::aes_round(up_state[127:0],   hk_pkg::RKEY[2*Step]);
      hi = hk_pkg::aes_round(up_state[255:128], hk_pkg::RKEY[2*Step+1]);
      if (Step % 2 == 1) begin
         // unpack mix: lo = a0 b0 a1 b1, hi = a2 b2 a3 b3
         state_in = {hi[127:96], lo[127:96], hi[95:64], lo[95:64],
                     hi[63:32],  lo[63:32],  hi[31:0],  lo[31:0]};
      end else begin
         state_in = {hi, lo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         state_ff <= state_in;
         orig_ff  <= up_orig;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;
   assign dn_orig  = orig_ff;
endmodule

// File: rtl/core/hk_fold.sv
// ---------------------------------------------------------------------------
// hk_fold
// Output stage: feed-forward, folds to 32 bits, holds result for the sink.
// ---------------------------------------------------------------------------
`include "haraka256_fold32_hash_core_defines.svh"
module hk_fold (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  logic [255:0] up_state,
   input  logic [255:0] up_orig,
   output logic         dn_valid,
   input  logic         dn_ready,
   output logic [31:0]  dn_digest
);
   logic         valid_ff;
   logic [31:0]  digest_ff, digest_in;
   logic [255:0] ff;
   logic [127:0] x;
   logic [63:0]  f64;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      ff  = up_state ^ up_orig;
      x   = ff[127:0] ^ ff[255:128];
      f64 = x[63:0] ^ x[127:64];
      // only the low 16 bits of the lower word are folded in
      digest_in = f64[63:32] ^ {16'h0000, f64[15:0] & hk_pkg::LowFoldMask};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         digest_ff <= digest_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_digest = digest_ff;

   `HK_ASSERT_NEXT(a_hold, clock, reset, valid_ff && !dn_ready, valid_ff && $stable(digest_ff), "result dropped under stall")
   `HK_ASSERT_NEXT(a_load, clock, reset, up_valid && up_ready, valid_ff, "accepted transaction lost")
   `HK_ASSERT_NOW(a_rdy, clock, reset, !valid_ff, up_ready, "empty stage not ready")
endmodule

// File: rtl/core/haraka256_fold32_hash_core.sv
// ---------------------------------------------------------------------------
// haraka256_fold32_hash_core
// 32-bit folded Haraka v2-256 digest of a 256-bit message, fully pipelined.
// ---------------------------------------------------------------------------
// channel | dir | contents
// req_    | in  | tdata[255:0] = msg_word0..msg_word3 (word0 lowest)
// rsp_    | out | tdata[31:0]  = digest
//
// Ten AES-round stages (two rounds per half-pair, mix after every second)
// plus one fold stage, each registered; one transaction per cycle while rsp_ is not stalled.
// Each stage holds one transaction; a stalled rsp_ side backs up stage by
// stage through ready, nothing lost or repeated.
// Synchronous active-high reset clears all valid bits only.
// ---------------------------------------------------------------------------
module haraka256_fold32_hash_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,   // msg_word0, msg_word1, msg_word2, msg_word3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // digest
);
   localparam int unsigned N = hk_pkg::AesRounds;

   logic         v [N+1];
   logic         r [N+1];
   logic [255:0] s [N+1];
   logic [255:0] o [N+1];

   // message words map straight to lanes: lo = orig[127:0], hi = orig[255:128]
   assign v[0]       = req_tvalid;
   assign req_tready = r[0];
   assign s[0]       = req_tdata;
   assign o[0]       = req_tdata;

   for (genvar g = 0; g < N; g++) begin : g_stage
      hk_stage #(.Step(g)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v[g]),
         .up_ready (r[g]),
         .up_state (s[g]),
         .up_orig  (o[g]),
         .dn_valid (v[g+1]),
         .dn_ready (r[g+1]),
         .dn_state (s[g+1]),
         .dn_orig  (o[g+1])
      );
   end

   hk_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (v[N]),
      .up_ready  (r[N]),
      .up_state  (s[N]),
      .up_orig   (o[N]),
      .dn_valid  (rsp_tvalid),
      .dn_ready  (rsp_tready),
      .dn_digest (rsp_tdata)
   );
endmodule

// File: tb/haraka256_fold32_hash_core_tb.sv
// ---------------------------------------------------------------------------
// haraka256_fold32_hash_core_tb
// Streams 256-bit messages into the hash core with random gaps and output
// stalls, predicts each folded Haraka digest in the bench and compares in order.
// ---------------------------------------------------------------------------
module haraka256_fold32_hash_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency  = 11;
   localparam int WatchLim = 5000;
   localparam int RandMsgs = 750;

   // AES S-box, kept local so the prediction does not lean on the design's tables
   localparam logic [7:0] SUB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // round constants, one row per AES round, lane 0 first
   localparam logic [31:0] RC [20][4] = '{
      '{32'h75817b9d,32'hb2c5fef0,32'he620c00a,32'h0684704c},
      '{32'h2f08f717,32'h640f6ba4,32'h88f3a06b,32'h8b66b4e1},
      '{32'h9f029114,32'hcf029d60,32'h53f28498,32'h3402de2d},
      '{32'hfd5b4f79,32'hbbf3bcaf,32'h2e7b4f08,32'h0ed6eae6},
      '{32'hbe397044,32'h79eecd1c,32'h4872448b,32'hcbcfb0cb},
      '{32'h2b8a057b,32'h8d5335ed,32'h6e9032b7,32'h7eeacdee},
      '{32'hda4fef1b,32'he2412761,32'h5e2e7cd0,32'h67c28f43},
      '{32'h1fc70b3b,32'h675ffde2,32'hafcacc07,32'h2924d9b0},
      '{32'hb9d465ee,32'hecdb8fca,32'he6867fe9,32'hab4d63f1},
      '{32'had037e33,32'h5b2a404f,32'hd4b7cd64,32'h1c30bf84},
      '{32'h8df69800,32'h69028b2e,32'h941723bf,32'hb2cc0bb9},
      '{32'h5c9d2d8a,32'h4aaa9ec8,32'hde6f5572,32'hfa0478a6},
      '{32'h29129fd4,32'h0efa4f2e,32'h6b772a12,32'hdfb49f2b},
      '{32'hbb6a12ee,32'h32d611ae,32'hf449a236,32'h1ea10344},
      '{32'h9ca8eca6,32'h5f9600c9,32'h4b050084,32'haf044988},
      '{32'h27e593ec,32'h78a2c7e3,32'h9d199c4f,32'h21025ed8},
      '{32'h82d40173,32'hb9282ecd,32'ha759c9b7,32'hbf3aaaf8},
      '{32'h10307d6b,32'h37f2efd9,32'h6186b017,32'h6260700d},
      '{32'hf6fc9ac6,32'h81c29153,32'h21300443,32'h5aca45c2},
      '{32'h36d1943a,32'h2caf92e8,32'h226b68bb,32'h9223973c}
   };

   typedef logic [31:0] lane4_type [4];

   function automatic logic [7:0] gf_dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one AES round over four 32-bit lanes (byte r of lane c = row r, column c)
   function automatic lane4_type aes_enc_round(input lane4_type s, input int k);
      logic [7:0] sb [16];
      logic [7:0] a0, a1, a2, a3;
      lane4_type  o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sb[4*c+r] = SUB[s[(c+r)%4][8*r +: 8]];
      for (int c = 0; c < 4; c++) begin
         a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
         o[c] = {gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3),
                 a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3,
                 a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3,
                 gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3} ^ RC[k][c];
      end
      return o;
   endfunction

   // full Haraka-256 permutation + feed-forward, folded 256 -> 128 -> 64 -> 32
   function automatic logic [31:0] folded_digest(input logic [255:0] msg);
      lane4_type   lo, hi, a, b;
      logic [31:0] x [4];
      logic [63:0] f64;
      for (int i = 0; i < 4; i++) begin
         lo[i] = msg[32*i +: 32];
         hi[i] = msg[128+32*i +: 32];
      end
      for (int rnd = 0; rnd < 5; rnd++) begin
         lo = aes_enc_round(lo, 4*rnd);
         hi = aes_enc_round(hi, 4*rnd+1);
         a  = aes_enc_round(lo, 4*rnd+2);
         b  = aes_enc_round(hi, 4*rnd+3);
         // 32-bit unpack mix between the halves
         lo = '{a[0], b[0], a[1], b[1]};
         hi = '{a[2], b[2], a[3], b[3]};
      end
      for (int i = 0; i < 4; i++)
         x[i] = lo[i] ^ hi[i] ^ msg[32*i +: 32] ^ msg[128+32*i +: 32];
      f64 = {x[1], x[0]} ^ {x[3], x[2]};
      // only the low 16 bits of the lower half fold in
      return f64[63:32] ^ {16'h0, f64[15:0]};
   endfunction

   class digest_scoreboard;
      logic [31:0] pending [$];
      int          errors;
      function void note_msg(input logic [255:0] msg);
         pending.push_back(folded_digest(msg));
      endfunction
      function void check_digest(input logic [31:0] got);
         logic [31:0] want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected digest %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("digest mismatch: expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;   // msg_word0, msg_word1, msg_word2, msg_word3
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;   // digest

   digest_scoreboard sb = new();
   logic [255:0]     msgs [$];
   int               idle_cycles;
   bit               no_gaps;   // stretches with the sender never idling

   haraka256_fold32_hash_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // build the message list: directed corners first, then random traffic
   function automatic logic [255:0] rand_msg();
      logic [255:0] m;
      for (int i = 0; i < 8; i++) m[32*i +: 32] = $urandom;
      return m;
   endfunction

   initial begin
      logic [255:0] m;
      msgs.push_back('0);
      msgs.push_back('1);
      msgs.push_back({4{64'haaaa_aaaa_aaaa_aaaa}});
      msgs.push_back({4{64'h5555_5555_5555_5555}});
      msgs.push_back({64'h0, 64'h0, 64'h0, 64'h1});
      msgs.push_back({64'h8000_0000_0000_0000, 192'h0});
      msgs.push_back({128'h0, {128{1'b1}}});
      msgs.push_back({{128{1'b1}}, 128'h0});
      msgs.push_back({64'h0, {64{1'b1}}, 64'h0, {64{1'b1}}});
      msgs.push_back(256'h1f1e1d1c1b1a191817161514131211100f0e0d0c0b0a09080706050403020100);
      for (int i = 0; i < 4; i++) begin
         m = '0; m[64*i +: 64] = '1; msgs.push_back(m);
      end
      for (int i = 0; i < RandMsgs; i++) begin
         m = rand_msg();
         // occasionally sparse or dense words so folded bits see extremes
         if ($urandom_range(0, 9) == 0) m[64*$urandom_range(0, 3) +: 64] = '0;
         if ($urandom_range(0, 9) == 0) m[64*$urandom_range(0, 3) +: 64] = '1;
         msgs.push_back(m);
      end
   end

   task automatic send_msgs();
      int gap;
      foreach (msgs[i]) begin
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         // tvalid drops only when the sender actually idles
         if (gap != 0 || i == msgs.size() / 2) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            // drain fully once mid-run
            if (i == msgs.size() / 2) begin
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= msgs[i];
         do @(posedge clock); while (!req_tready);
         sb.note_msg(msgs[i]);
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      end
      req_tvalid <= 1'b0;
   endtask

   // result side: random stalls with occasional full-rate stretches
   initial begin
      int  stall;
      bit  fast;
      rsp_tready = 1'b0;
      fast = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) fast = ~fast;
         stall = fast ? 0 : $urandom_range(0, 7);
         // tready stays high into the next transaction when no stall is drawn
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         sb.check_digest(rsp_tdata);
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLim) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      no_gaps    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_msgs();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (Latency * 4) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
